// ===== rtl/core/slfp_pkg.sv =====
// Shared types and constants for the sync/length/type frame parser.
// Holds field widths, register indexes and the controller/datapath command
// and status structs. No dependencies.
package slfp_pkg;

    localparam int BYTE_W          = 8;
    localparam int IDX_W           = 6;
    localparam int LEN_W           = 7;
    localparam int MAX_PAYLOAD_DEF = 64;

    // APB register map: byte address 4*i
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_SYNC1 = 2'd0;
    localparam logic [1:0] REG_SYNC2 = 2'd1;
    localparam logic [1:0] REG_END1  = 2'd2;
    localparam logic [1:0] REG_END2  = 2'd3;

    localparam logic [BYTE_W-1:0] SYNC1_RST = 8'd170;
    localparam logic [BYTE_W-1:0] SYNC2_RST = 8'd85;
    localparam logic [BYTE_W-1:0] END1_RST  = 8'd13;
    localparam logic [BYTE_W-1:0] END2_RST  = 8'd10;

    // Commands from controller to datapath
    typedef struct packed {
        logic len_load;   // latch declared length, clear receive count
        logic type_load;  // latch type byte
        logic data_wr;    // store payload beat, advance receive count
        logic idx_clr;    // restart emission index
        logic idx_inc;    // advance emission index
        logic rd_en;      // read payload store at emission index
        logic out_load;   // fill output register
    } slfp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_sync1;
        logic is_sync2;
        logic is_end1;
        logic is_end2;
        logic len_over;   // incoming length byte exceeds the store depth
        logic len_zero;   // held length is zero
        logic data_done;  // this payload beat is the last one
        logic emit_last;  // current emission index is the final result
        logic out_free;   // output register can take a result this cycle
    } slfp_sts_t;

endpackage

// ===== rtl/core/sync_length_type_frame_parser.sv =====
// Top level of the sync/length/type frame parser.
// Depends on slfp_pkg, slfp_ctrl, slfp_dp (and slfp_ram through slfp_dp).
//
// Usage:
//   s_* carries received bytes, one per beat. The block hunts for frames
//   sync1, sync2, length, type, payload, end1, end2 (byte values set over
//   APB at addresses 0x0, 0x4, 0x8, 0xC). A frame with a good trailer comes
//   out on m_* as one beat per payload byte, or one empty beat for a
//   zero-length frame; m_tlast marks the final beat. Bad trailers and
//   lengths above MAX_PAYLOAD drop the frame silently.
//   While parsing, the block takes one byte per cycle. After the second
//   trailer byte it stops taking input and reads the payload store out,
//   each result beat a store read and then an output register load, so
//   s_tready stays low for the whole walk; an empty frame needs only
//   the output register load, with no store read.
//   If the receiver stalls, the output register holds its beat and the
//   store walk waits; while the final beat waits the block already hunts.
//   Reset restores the default sync and trailer bytes, clears the parse
//   state and the output valid flag; the payload store is not cleared.
module sync_length_type_frame_parser import slfp_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input byte stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [7:0] frame_type, [15:8] payload_byte,
                                             // [21:16] byte_index, [28:22] payload_length,
                                             // [31:29] zero
    output logic                  m_tuser,   // [0] has_payload
    output logic                  m_tlast    // last_of_frame
);

    slfp_cmd_t         cmd;
    slfp_sts_t         sts;
    logic [BYTE_W-1:0] out_type, out_payload;
    logic [IDX_W-1:0]  out_index;
    logic [LEN_W-1:0]  out_length;

    assign pready = 1'b1;

    slfp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    slfp_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .rx_byte         (s_tdata),
        .cmd             (cmd),
        .sts             (sts),
        .m_tready        (m_tready),
        .out_valid       (m_tvalid),
        .out_type        (out_type),
        .out_payload     (out_payload),
        .out_index       (out_index),
        .out_length      (out_length),
        .out_has_payload (m_tuser),
        .out_last        (m_tlast)
    );

    // Pack result fields, first field lowest
    assign m_tdata = {3'b000, out_length, out_index, out_payload, out_type};

endmodule

// ===== rtl/core/slfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the payload store. No dependencies.
module slfp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/slfp_dp.sv =====
// Datapath of the frame parser: config registers, byte compares, length,
// type and counters, payload store and the output register.
// Depends on slfp_pkg and slfp_ram.
module slfp_dp import slfp_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    // Input byte
    input  logic [BYTE_W-1:0]     rx_byte,
    // Controller link
    input  slfp_cmd_t             cmd,
    output slfp_sts_t             sts,
    // Result register
    input  logic                  m_tready,
    output logic                  out_valid,
    output logic [BYTE_W-1:0]     out_type,
    output logic [BYTE_W-1:0]     out_payload,
    output logic [IDX_W-1:0]      out_index,
    output logic [LEN_W-1:0]      out_length,
    output logic                  out_has_payload,
    output logic                  out_last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_PAYLOAD);
    localparam logic [BYTE_W-1:0] MAX_BYTE = BYTE_W'(MAX_PAYLOAD);

    logic [BYTE_W-1:0] sync1_reg, sync2_reg, end1_reg, end2_reg;
    logic [LEN_W-1:0]  len_reg, rcv_reg, idx_reg;
    logic [BYTE_W-1:0] type_reg;
    logic [BYTE_W-1:0] ram_q;
    logic              cfg_wr;
    logic [1:0]        reg_sel;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_type_reg, out_payload_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic [LEN_W-1:0]  out_length_reg;
    logic              out_has_payload_reg, out_last_reg;
    logic              store_we;

    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync1_reg <= SYNC1_RST;
            sync2_reg <= SYNC2_RST;
            end1_reg  <= END1_RST;
            end2_reg  <= END2_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_SYNC1: sync1_reg <= pwdata[BYTE_W-1:0];
                REG_SYNC2: sync2_reg <= pwdata[BYTE_W-1:0];
                REG_END1:  end1_reg  <= pwdata[BYTE_W-1:0];
                REG_END2:  end2_reg  <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        prdata = '0;
        case (reg_sel)
            REG_SYNC1: prdata[BYTE_W-1:0] = sync1_reg;
            REG_SYNC2: prdata[BYTE_W-1:0] = sync2_reg;
            REG_END1:  prdata[BYTE_W-1:0] = end1_reg;
            REG_END2:  prdata[BYTE_W-1:0] = end2_reg;
            default:   prdata = '0;
        endcase
    end

    // Frame header and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            rcv_reg  <= '0;
            type_reg <= '0;
            idx_reg  <= '0;
        end else begin
            if (cmd.len_load) begin
                len_reg <= rx_byte[LEN_W-1:0];
                rcv_reg <= '0;
            end else if (cmd.data_wr) begin
                rcv_reg <= rcv_reg + LEN_W'(1);
            end
            if (cmd.type_load) begin
                type_reg <= rx_byte;
            end
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + LEN_W'(1);
            end
        end
    end

    // Payload store
    assign store_we = cmd.data_wr && (rcv_reg < MAX_LEN);

    slfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (rcv_reg[AW-1:0]),
        .wdata (rx_byte),
        .re    (cmd.rd_en),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_q)
    );

    // Status toward the controller
    always_comb begin
        sts.is_sync1  = (rx_byte == sync1_reg);
        sts.is_sync2  = (rx_byte == sync2_reg);
        sts.is_end1   = (rx_byte == end1_reg);
        sts.is_end2   = (rx_byte == end2_reg);
        sts.len_over  = (rx_byte > MAX_BYTE);
        sts.len_zero  = (len_reg == '0);
        sts.data_done = ((rcv_reg + LEN_W'(1)) >= len_reg);
        sts.emit_last = (len_reg == '0) || ((idx_reg + LEN_W'(1)) == len_reg);
        sts.out_free  = !out_valid_reg || m_tready;
    end

    // Output register: hold until taken, refill on load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_type_reg        <= type_reg;
            out_payload_reg     <= (len_reg == '0) ? '0 : ram_q;
            out_index_reg       <= idx_reg[IDX_W-1:0];
            out_length_reg      <= len_reg;
            out_has_payload_reg <= (len_reg != '0);
            out_last_reg        <= sts.emit_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_type        = out_type_reg;
    assign out_payload     = out_payload_reg;
    assign out_index       = out_index_reg;
    assign out_length      = out_length_reg;
    assign out_has_payload = out_has_payload_reg;
    assign out_last        = out_last_reg;

endmodule

// ===== rtl/core/slfp_ctrl.sv =====
// Controller of the frame parser: hunt/parse state machine and the
// emission sequencer that walks the payload store.
// Depends on slfp_pkg.
module slfp_ctrl import slfp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  slfp_sts_t sts,
    output slfp_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_SYNC1,
        ST_SYNC2,
        ST_LEN,
        ST_TYPE,
        ST_DATA,
        ST_END1,
        ST_END2,
        ST_FETCH,
        ST_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   in_acc;

    // Take bytes only while parsing
    assign s_tready = (state_reg != ST_FETCH) && (state_reg != ST_LOAD);
    assign in_acc   = s_tvalid && s_tready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_SYNC1: begin
                if (in_acc && sts.is_sync1) begin
                    state_next = ST_SYNC2;
                end
            end
            ST_SYNC2: begin
                if (in_acc) begin
                    if (sts.is_sync2) begin
                        state_next = ST_LEN;
                    end else if (sts.is_sync1) begin
                        state_next = ST_SYNC2;
                    end else begin
                        state_next = ST_SYNC1;
                    end
                end
            end
            ST_LEN: begin
                if (in_acc) begin
                    if (sts.len_over) begin
                        state_next = ST_SYNC1;
                    end else begin
                        cmd.len_load = 1'b1;
                        state_next   = ST_TYPE;
                    end
                end
            end
            ST_TYPE: begin
                if (in_acc) begin
                    cmd.type_load = 1'b1;
                    state_next    = sts.len_zero ? ST_END1 : ST_DATA;
                end
            end
            ST_DATA: begin
                if (in_acc) begin
                    cmd.data_wr = 1'b1;
                    if (sts.data_done) begin
                        state_next = ST_END1;
                    end
                end
            end
            ST_END1: begin
                if (in_acc) begin
                    state_next = sts.is_end1 ? ST_END2 : ST_SYNC1;
                end
            end
            ST_END2: begin
                if (in_acc) begin
                    if (sts.is_end2) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = sts.len_zero ? ST_LOAD : ST_FETCH;
                    end else begin
                        state_next = ST_SYNC1;
                    end
                end
            end
            ST_FETCH: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.emit_last) begin
                        state_next = ST_SYNC1;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_FETCH;
                    end
                end
            end
            default: state_next = ST_SYNC1;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SYNC1;
        end else begin
            state_reg <= state_next;
        end
    end

    // A result is loaded only into a free output register
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending beat");

    // The final result of a frame hands the block back to the hunt
    a_last_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && sts.emit_last) |=> (state_reg == ST_SYNC1) && s_tready)
        else $error("no return to hunt after final result");

    // A store read is always followed by a load attempt
    a_fetch_then_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |=> (state_reg == ST_LOAD) && !s_tready)
        else $error("store read not followed by load");

    // Each payload write leaves the parser in the data phase or at the first trailer byte
    a_wr_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.data_wr |=> (state_reg == ST_DATA) || (state_reg == ST_END1))
        else $error("payload write outside the data phase");

endmodule

// ===== tb/sync_length_type_frame_parser_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the sync/length/type frame parser: byte stream in, frame beats out.
// Depends on slfp_pkg and sync_length_type_frame_parser; holds a frame predictor
// and scoreboard in slfp_tb_pkg plus the stimulus and checking top.

package slfp_tb_pkg;
    import slfp_pkg::*;

    typedef enum bit [2:0] {
        HUNT_SYNC1,
        HUNT_SYNC2,
        GET_LEN,
        GET_TYPE,
        GET_DATA,
        CHK_END1,
        CHK_END2
    } parse_phase_e;

    typedef struct packed {
        bit [7:0] frame_type;
        bit [7:0] payload_byte;
        bit [5:0] byte_index;
        bit [6:0] payload_length;
        bit       has_payload;
        bit       last_of_frame;
    } frame_beat_t;

    // Frame predictor plus the queue of beats it still waits for
    class frame_scoreboard;
        bit [7:0]     sync1_val;
        bit [7:0]     sync2_val;
        bit [7:0]     end1_val;
        bit [7:0]     end2_val;
        parse_phase_e phase;
        bit [6:0]     frame_len;
        bit [6:0]     rx_count;
        bit [7:0]     held_type;
        bit [7:0]     payload_mem [MAX_PAYLOAD_DEF];
        frame_beat_t  expected_beats [$];
        int unsigned  err_count;
        int unsigned  beat_count;
        int unsigned  frame_count;

        function new();
            sync1_val   = SYNC1_RST;
            sync2_val   = SYNC2_RST;
            end1_val    = END1_RST;
            end2_val    = END2_RST;
            phase       = HUNT_SYNC1;
            frame_len   = '0;
            rx_count    = '0;
            held_type   = '0;
            err_count   = 0;
            beat_count  = 0;
            frame_count = 0;
        endfunction

        function int unsigned pending();
            return expected_beats.size();
        endfunction

        function void set_register(bit [1:0] idx, bit [7:0] value);
            case (idx)
                REG_SYNC1: sync1_val = value;
                REG_SYNC2: sync2_val = value;
                REG_END1:  end1_val  = value;
                REG_END2:  end2_val  = value;
                default:   ;
            endcase
        endfunction

        function void push_beat(bit [7:0] data, bit [5:0] pos, bit valid, bit last);
            frame_beat_t beat;
            beat.frame_type     = held_type;
            beat.payload_byte   = data;
            beat.byte_index     = pos;
            beat.payload_length = frame_len;
            beat.has_payload    = valid;
            beat.last_of_frame  = last;
            expected_beats.push_back(beat);
        endfunction

        // Advance the parse by one accepted byte; queue the beats of a good frame
        function void note_byte(bit [7:0] b);
            case (phase)
                HUNT_SYNC1: begin
                    if (b == sync1_val)
                        phase = HUNT_SYNC2;
                end
                HUNT_SYNC2: begin
                    if (b == sync2_val)
                        phase = GET_LEN;
                    else if (b == sync1_val)
                        phase = HUNT_SYNC2;
                    else
                        phase = HUNT_SYNC1;
                end
                GET_LEN: begin
                    if (b > MAX_PAYLOAD_DEF) begin
                        phase = HUNT_SYNC1;
                    end else begin
                        frame_len = b[6:0];
                        rx_count  = '0;
                        phase     = GET_TYPE;
                    end
                end
                GET_TYPE: begin
                    held_type = b;
                    phase     = (frame_len == 0) ? CHK_END1 : GET_DATA;
                end
                GET_DATA: begin
                    payload_mem[rx_count[5:0]] = b;
                    rx_count = rx_count + 7'd1;
                    if (rx_count >= frame_len)
                        phase = CHK_END1;
                end
                CHK_END1: begin
                    phase = (b == end1_val) ? CHK_END2 : HUNT_SYNC1;
                end
                CHK_END2: begin
                    if (b == end2_val) begin
                        frame_count++;
                        if (frame_len == 0) begin
                            push_beat(8'h00, 6'd0, 1'b0, 1'b1);
                        end else begin
                            for (int i = 0; i < frame_len; i++)
                                push_beat(payload_mem[i], i[5:0], 1'b1, i + 1 == frame_len);
                        end
                    end
                    phase = HUNT_SYNC1;
                end
                default: phase = HUNT_SYNC1;
            endcase
        endfunction

        task report_mismatch(string msg);
            err_count++;
            if (err_count <= 40)
                $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        // Compare one output beat against the oldest expected beat
        task check_beat(frame_beat_t got);
            frame_beat_t want;
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("result beat 0x%h with nothing expected", got));
                return;
            end
            want = expected_beats.pop_front();
            beat_count++;
            if (got.frame_type != want.frame_type)
                report_mismatch($sformatf("beat %0d frame_type 0x%h, expected 0x%h",
                                          beat_count, got.frame_type, want.frame_type));
            if (got.payload_byte != want.payload_byte)
                report_mismatch($sformatf("beat %0d payload_byte 0x%h, expected 0x%h",
                                          beat_count, got.payload_byte, want.payload_byte));
            if (got.byte_index != want.byte_index)
                report_mismatch($sformatf("beat %0d byte_index %0d, expected %0d",
                                          beat_count, got.byte_index, want.byte_index));
            if (got.payload_length != want.payload_length)
                report_mismatch($sformatf("beat %0d payload_length %0d, expected %0d",
                                          beat_count, got.payload_length,
                                          want.payload_length));
            if (got.has_payload != want.has_payload)
                report_mismatch($sformatf("beat %0d has_payload %0d, expected %0d",
                                          beat_count, got.has_payload, want.has_payload));
            if (got.last_of_frame != want.last_of_frame)
                report_mismatch($sformatf("beat %0d last_of_frame %0d, expected %0d",
                                          beat_count, got.last_of_frame,
                                          want.last_of_frame));
        endtask
    endclass

endpackage

module sync_length_type_frame_parser_tb;
    import slfp_pkg::*;
    import slfp_tb_pkg::*;

    typedef enum int {
        GOOD_FRAME,
        RESYNC_FRAME,
        BAD_END1,
        BAD_END2,
        OVERSIZE,
        LINE_NOISE
    } frame_kind_e;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;   // [7:0] rx_byte
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;         // [7:0] frame_type, [15:8] payload_byte,
                                            // [21:16] byte_index, [28:22] payload_length
    logic                  m_tuser;         // [0] has_payload
    logic                  m_tlast;         // last_of_frame

    frame_scoreboard sb = new();
    frame_beat_t     beat_seen;

    // Stimulus-side copy of the register values
    bit [7:0]    cfg [4];
    int unsigned gap_max;
    int unsigned burst_left;
    int unsigned byte_count;
    int unsigned noise_count;
    int unsigned setting_count;
    bit          stall_free = 1'b1;
    bit [15:0]   stall_pat  = 16'hFFFF;
    bit [3:0]    stall_step = '0;

    sync_length_type_frame_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Receiver: stall on a rotating per-phase pattern
    always @(posedge aclk) begin
        stall_step <= stall_step + 4'd1;
        m_tready   <= stall_free || stall_pat[stall_step];
    end

    // Watch register writes and both streams; feed the scoreboard
    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel && penable && pwrite && pready)
                sb.set_register(paddr[3:2], pwdata[7:0]);
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata);
            if (m_tvalid === 1'b1 && m_tready) begin
                beat_seen.frame_type     = m_tdata[7:0];
                beat_seen.payload_byte   = m_tdata[15:8];
                beat_seen.byte_index     = m_tdata[21:16];
                beat_seen.payload_length = m_tdata[28:22];
                beat_seen.has_payload    = m_tuser;
                beat_seen.last_of_frame  = m_tlast;
                sb.check_beat(beat_seen);
            end
        end
    end

    // Hold one byte until accepted; open a random gap between bursts
    task automatic send_byte(input bit [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        byte_count++;
    endtask

    function automatic bit [7:0] other_than(input bit [7:0] v);
        bit [7:0] r;
        r = 8'($urandom_range(0, 254));
        return (r >= v) ? r + 8'd1 : r;
    endfunction

    // Send one frame shaped by kind: good, resynced, broken trailer or oversized
    task automatic send_frame(input frame_kind_e kind, input int unsigned len);
        int unsigned n_sync;
        n_sync = (kind == RESYNC_FRAME) ? $urandom_range(2, 4) : 1;
        repeat (n_sync) send_byte(cfg[REG_SYNC1]);
        send_byte(cfg[REG_SYNC2]);
        if (kind == OVERSIZE) begin
            send_byte(8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)));
        end else begin
            send_byte(8'(len));
            send_byte(8'($urandom_range(0, 255)));
            repeat (len) send_byte(8'($urandom_range(0, 255)));
            send_byte(kind == BAD_END1 ? other_than(cfg[REG_END1]) : cfg[REG_END1]);
            send_byte(kind == BAD_END2 ? other_than(cfg[REG_END2]) : cfg[REG_END2]);
        end
    endtask

    task automatic send_noise();
        int unsigned n;
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
        noise_count += n;
    endtask

    // Stop sending, wait out every expected beat, then let the block go idle
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    // APB setup phase, then access phase, then idle before the next transfer
    task automatic write_reg(input logic [1:0] idx, input bit [7:0] value);
        cfg[idx] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setting(input bit [7:0] s1, input bit [7:0] s2,
                                 input bit [7:0] e1, input bit [7:0] e2);
        write_reg(REG_SYNC1, s1);
        write_reg(REG_SYNC2, s2);
        write_reg(REG_END1, e1);
        write_reg(REG_END2, e2);
        setting_count++;
    endtask

    function automatic frame_kind_e pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return GOOD_FRAME;
        if (r < 65) return RESYNC_FRAME;
        if (r < 72) return BAD_END1;
        if (r < 79) return BAD_END2;
        if (r < 87) return OVERSIZE;
        return LINE_NOISE;
    endfunction

    initial begin
        frame_kind_e kind;
        int unsigned len;
        int unsigned phase_start;
        bit [7:0]    shared_sync;

        cfg[REG_SYNC1] = SYNC1_RST;
        cfg[REG_SYNC2] = SYNC2_RST;
        cfg[REG_END1]  = END1_RST;
        cfg[REG_END2]  = END2_RST;
        gap_max       = 2;
        burst_left    = 0;
        byte_count    = 0;
        noise_count   = 0;
        setting_count = 1;
        stall_pat     = 16'($urandom());
        stall_pat[0]  = 1'b1;
        stall_free    = 1'b0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty frame, repeated sync with zero data, oversized length, empty frame
        // with extreme type and a bad first trailer made of sync bytes, bad second trailer
        send_frame(GOOD_FRAME, 0);
        send_byte(SYNC1_RST);
        send_byte(SYNC1_RST);
        send_byte(SYNC2_RST);
        send_byte(8'd1);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(END1_RST);
        send_byte(END2_RST);
        send_byte(SYNC1_RST);
        send_byte(SYNC2_RST);
        send_byte(8'(MAX_PAYLOAD_DEF + 1));
        send_byte(SYNC1_RST);
        send_byte(SYNC2_RST);
        send_byte(8'd0);
        send_byte(8'hFF);
        send_byte(SYNC1_RST);
        send_byte(SYNC2_RST);
        send_frame(BAD_END2, 0);
        drain();

        // Random phases, each under its own register setting and idling style
        for (int ph = 0; ph < 5 || (sb.beat_count < 48 && ph < 12); ph++) begin
            case (ph % 5)
                0: apply_setting(8'h00, 8'h00, 8'h00, 8'h00);
                1: apply_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                2: apply_setting(8'($urandom()), 8'($urandom()),
                                 8'($urandom()), 8'($urandom()));
                3: begin
                    shared_sync = 8'($urandom());
                    apply_setting(shared_sync, shared_sync,
                                  8'($urandom()), 8'($urandom()));
                end
                default: apply_setting(SYNC1_RST, SYNC2_RST, END1_RST, END2_RST);
            endcase
            gap_max      = (ph % 3 == 0) ? 0 : $urandom_range(2, 8);
            stall_free   = (ph % 4 == 1);
            stall_pat    = 16'($urandom());
            stall_pat[$urandom_range(0, 15)] = 1'b1;

            if (ph == 1)
                send_frame(GOOD_FRAME, MAX_PAYLOAD_DEF);
            phase_start = byte_count - noise_count;
            while (byte_count - noise_count - phase_start < 20) begin
                kind = pick_kind();
                len  = ($urandom_range(0, 99) < 4) ? $urandom_range(0, MAX_PAYLOAD_DEF)
                                                    : $urandom_range(0, 6);
                if (kind == LINE_NOISE)
                    send_noise();
                else
                    send_frame(kind, len);
                // In phase 2, now and then hold off until every pending beat has come out
                if (ph == 2 && sb.frame_count % 4 == 3 && $urandom_range(0, 3) == 0)
                    drain();
            end
            drain();
        end

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected beats never arrived", sb.pending()));
        $display("Run covered %0d input bytes (%0d noise) under %0d register settings,",
                 byte_count, noise_count, setting_count);
        $display("and %0d good frames carrying %0d result beats.",
                 sb.frame_count, sb.beat_count);
        if (sb.err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/slfp_pkg.sv
rtl/core/slfp_ram.sv
rtl/core/slfp_dp.sv
rtl/core/slfp_ctrl.sv
rtl/core/sync_length_type_frame_parser.sv
tb/sync_length_type_frame_parser_tb.sv
